### design/sacl_pkg.sv
// ============================================================================
// sacl_pkg
// Shared types and constants of the set-associative cache tag lookup: the
// access and result transfer types, the controller states and the register
// map of the configuration port.
// ============================================================================
package sacl_pkg;

    localparam int ADDR_W    = 64;
    localparam int PEN_W     = 10;
    localparam int CYCLES_W  = 11;
    localparam int APB_W     = 32;
    localparam int PADDR_W   = 3;

    localparam logic [PEN_W-1:0] MISS_PEN_RESET = 10'd30;
    localparam logic [PEN_W-1:0] WB_PEN_RESET   = 10'd2;

    localparam logic REG_MISS_PENALTY      = 1'b0;
    localparam logic REG_WRITEBACK_PENALTY = 1'b1;

    typedef struct packed {
        logic              is_write;
        logic [ADDR_W-1:0] address;
    } t_access;

    typedef struct packed {
        logic                hit;
        logic                dirty_writeback;
        logic [CYCLES_W-1:0] penalty_cycles;
    } t_result;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_UPDATE
    } t_state;

endpackage

### design/sacl_way_select.sv
// ============================================================================
// sacl_way_select
// Searches the ways of one set for a valid matching tag and, on a miss,
// picks the way to fill: the highest-numbered invalid way, or else the
// lowest-numbered way holding the greatest age.
// ============================================================================
module sacl_way_select #(
    parameter int WAYS  = 4,
    parameter int TAG_W = 52,
    parameter int AGE_W = 3,
    parameter int WAY_W = 2
) (
    input  logic [WAYS-1:0]             i_valid,
    input  logic [WAYS-1:0][AGE_W-1:0]  i_age,
    input  logic [WAYS-1:0][TAG_W-1:0]  i_tags,
    input  logic [TAG_W-1:0]            i_tag,
    output logic                        o_hit,
    output logic [WAY_W-1:0]            o_way
);

    logic [WAYS-1:0]  w_match;
    logic [WAYS-1:0]  w_oldest;
    logic [WAY_W-1:0] w_hit_way;
    logic [WAY_W-1:0] w_inv_way;
    logic [WAY_W-1:0] w_old_way;
    logic             w_have_inv;

    always_comb begin
        for (int i = 0; i < WAYS; i++) begin
            w_match[i]  = i_valid[i] && (i_tags[i] == i_tag);
            w_oldest[i] = 1'b1;
            for (int j = 0; j < WAYS; j++) begin
                if (j < i) begin
                    if (!(i_age[i] > i_age[j])) begin
                        w_oldest[i] = 1'b0;
                    end
                end else if (j > i) begin
                    if (i_age[i] < i_age[j]) begin
                        w_oldest[i] = 1'b0;
                    end
                end
            end
        end
    end

    always_comb begin
        w_hit_way = '0;
        w_old_way = '0;
        for (int i = WAYS - 1; i >= 0; i--) begin
            if (w_match[i]) begin
                w_hit_way = WAY_W'(i);
            end
            if (w_oldest[i]) begin
                w_old_way = WAY_W'(i);
            end
        end
        w_inv_way = '0;
        for (int i = 0; i < WAYS; i++) begin
            if (!i_valid[i]) begin
                w_inv_way = WAY_W'(i);
            end
        end
    end

    assign w_have_inv = ~&i_valid;
    assign o_hit      = |w_match;
    assign o_way      = o_hit      ? w_hit_way :
                        w_have_inv ? w_inv_way : w_old_way;

endmodule

### design/set_assoc_cache_tag_lookup.sv
// ============================================================================
// set_assoc_cache_tag_lookup
// Tag lookup of a set-associative write-back cache with age-based LRU.
// ============================================================================
// Each access transfer is looked up in order: the row of its set is read
// from the tag memory and the state memory, the ways are searched and the
// victim chosen, and the updated row is written back while the result is
// loaded into the output register. The next access is taken only after that
// write-back, so a new access is not accepted while one is in flight; a
// result that waits in the output register holds the write-back. After
// reset the state memory is cleared one set per cycle, all SETS sets (256 by
// default), during which no access is taken.
// ============================================================================
module set_assoc_cache_tag_lookup #(
    parameter int LINE_BYTES = 16,
    parameter int WAYS       = 4,
    parameter int SETS       = 256
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  sacl_pkg::t_access         i_in_data,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output sacl_pkg::t_result         o_out_data,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [sacl_pkg::PADDR_W-1:0] paddr,
    input  logic [sacl_pkg::APB_W-1:0]   pwdata,
    output logic [sacl_pkg::APB_W-1:0]   prdata,
    output logic                      pready
);

    import sacl_pkg::*;

    localparam int OFF_BITS = $countones(LINE_BYTES - 1);
    localparam int IDX_BITS = $countones(SETS - 1);
    localparam int TAG_W    = ADDR_W - OFF_BITS - IDX_BITS;
    localparam int SET_AW   = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int AGE_W    = $clog2(WAYS + 1);
    localparam int DRT_LSB  = WAYS;
    localparam int AGE_LSB  = 2 * WAYS;
    localparam int META_W   = WAYS * (2 + AGE_W);
    localparam logic [SET_AW-1:0] IDX_MASK = SET_AW'(SETS - 1);
    localparam logic [SET_AW-1:0] SET_LAST = SET_AW'(SETS - 1);
    localparam logic [AGE_W-1:0]  AGE_CAP  = AGE_W'(WAYS);

    t_state r_state, n_state;

    logic [PEN_W-1:0]  r_miss_pen;
    logic [PEN_W-1:0]  r_wb_pen;
    logic [SET_AW-1:0] r_clr_idx;

    logic [WAYS-1:0][TAG_W-1:0] r_tag_mem  [SETS];
    logic [META_W-1:0]          r_meta_mem [SETS];

    logic [WAYS-1:0][TAG_W-1:0] r_tag_rd;
    logic [META_W-1:0]          r_meta_rd;
    logic [SET_AW-1:0]          r_set;
    logic [TAG_W-1:0]           r_tag;
    logic                       r_wr;
    logic                       r_hit;
    logic [WAY_W-1:0]           r_way;
    logic                       r_out_valid;
    t_result                    r_out_data;

    logic                       w_accept;
    logic                       w_in_ready;
    logic                       w_clear_we;
    logic                       w_commit;
    logic                       w_cfg_we;
    logic [SET_AW-1:0]          w_set;
    logic [TAG_W-1:0]           w_tag;
    logic                       w_sel_hit;
    logic [WAY_W-1:0]           w_sel_way;
    logic [WAYS-1:0]            w_valid_rd;
    logic [WAYS-1:0]            w_dirty_rd;
    logic [WAYS-1:0][AGE_W-1:0] w_age_rd;
    logic [AGE_W-1:0]           w_pivot;
    logic [WAYS-1:0]            w_valid_new;
    logic [WAYS-1:0]            w_dirty_new;
    logic [WAYS-1:0][AGE_W-1:0] w_age_new;
    logic [WAYS-1:0][TAG_W-1:0] w_tag_new;
    logic                       w_wb;
    logic [CYCLES_W-1:0]        w_cycles;
    logic [META_W-1:0]          w_meta_wdata;
    logic [SET_AW-1:0]          w_meta_waddr;

    // Configuration port.
    assign pready   = 1'b1;
    assign w_cfg_we = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_miss_pen <= MISS_PEN_RESET;
            r_wb_pen   <= WB_PEN_RESET;
        end else if (w_cfg_we) begin
            case (paddr[2])
                REG_MISS_PENALTY:      r_miss_pen <= pwdata[PEN_W-1:0];
                REG_WRITEBACK_PENALTY: r_wb_pen   <= pwdata[PEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_MISS_PENALTY:      prdata = APB_W'(r_miss_pen);
            REG_WRITEBACK_PENALTY: prdata = APB_W'(r_wb_pen);
            default:               prdata = '0;
        endcase
    end

    // Controller.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr_idx == SET_LAST) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_LOOKUP;
                end
            end
            ST_LOOKUP: n_state = ST_UPDATE;
            ST_UPDATE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    always_comb begin
        w_in_ready = 1'b0;
        w_clear_we = 1'b0;
        w_commit   = 1'b0;
        case (r_state)
            ST_CLEAR:  w_clear_we = 1'b1;
            ST_IDLE:   w_in_ready = 1'b1;
            ST_LOOKUP: ;
            ST_UPDATE: w_commit = !r_out_valid || i_out_ready;
            default:   ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_clr_idx <= '0;
        end else begin
            r_state <= n_state;
            if (w_clear_we) begin
                r_clr_idx <= r_clr_idx + SET_AW'(1);
            end
        end
    end

    assign o_in_ready = w_in_ready;
    assign w_accept   = i_in_valid && w_in_ready;

    // Address split.
    assign w_set = i_in_data.address[OFF_BITS +: SET_AW] & IDX_MASK;
    assign w_tag = TAG_W'(i_in_data.address >> (OFF_BITS + IDX_BITS));

    // Memories.
    assign w_meta_waddr = w_clear_we ? r_clr_idx : r_set;
    assign w_meta_wdata = w_clear_we ? '0 : {w_age_new, w_dirty_new, w_valid_new};

    always_ff @(posedge i_clk) begin
        if (w_clear_we || w_commit) begin
            r_meta_mem[w_meta_waddr] <= w_meta_wdata;
        end
        if (w_commit) begin
            r_tag_mem[r_set] <= w_tag_new;
        end
        if (w_accept) begin
            r_meta_rd <= r_meta_mem[w_set];
            r_tag_rd  <= r_tag_mem[w_set];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_set <= w_set;
            r_tag <= w_tag;
            r_wr  <= i_in_data.is_write;
        end
        if (r_state == ST_LOOKUP) begin
            r_hit <= w_sel_hit;
            r_way <= w_sel_way;
        end
    end

    assign w_valid_rd = r_meta_rd[0 +: WAYS];
    assign w_dirty_rd = r_meta_rd[DRT_LSB +: WAYS];
    assign w_age_rd   = r_meta_rd[AGE_LSB +: WAYS * AGE_W];

    sacl_way_select #(
        .WAYS  (WAYS),
        .TAG_W (TAG_W),
        .AGE_W (AGE_W),
        .WAY_W (WAY_W)
    ) u_way_select (
        .i_valid (w_valid_rd),
        .i_age   (w_age_rd),
        .i_tags  (r_tag_rd),
        .i_tag   (r_tag),
        .o_hit   (w_sel_hit),
        .o_way   (w_sel_way)
    );

    // Row update.
    assign w_pivot = w_age_rd[r_way];
    assign w_wb    = !r_hit && w_valid_rd[r_way] && w_dirty_rd[r_way];

    always_comb begin
        for (int i = 0; i < WAYS; i++) begin
            w_valid_new[i] = w_valid_rd[i];
            w_dirty_new[i] = w_dirty_rd[i];
            w_tag_new[i]   = r_tag_rd[i];
            if ((w_age_rd[i] <= w_pivot) && (w_age_rd[i] < AGE_CAP)) begin
                w_age_new[i] = w_age_rd[i] + AGE_W'(1);
            end else begin
                w_age_new[i] = w_age_rd[i];
            end
            if (r_way == WAY_W'(i)) begin
                w_age_new[i]   = '0;
                w_valid_new[i] = 1'b1;
                if (r_hit) begin
                    w_dirty_new[i] = w_dirty_rd[i] | r_wr;
                end else begin
                    w_dirty_new[i] = r_wr;
                    w_tag_new[i]   = r_tag;
                end
            end
        end
    end

    assign w_cycles = (r_hit ? '0 : CYCLES_W'(r_miss_pen)) + (w_wb ? CYCLES_W'(r_wb_pen) : '0);

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_out_data.hit             <= r_hit;
            r_out_data.dirty_writeback <= w_wb;
            r_out_data.penalty_cycles  <= w_cycles;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Assertions.
    a_result_from_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_commit))
        else $error("A result appeared without a row write-back.");

    a_hit_way_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_UPDATE && r_hit) |-> w_valid_rd[r_way])
        else $error("A hit was recorded on an invalid way.");

    a_clear_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> !r_out_valid)
        else $error("A result is pending while the state memory is cleared.");

endmodule

### verif/tb_set_assoc_cache_tag_lookup.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_set_assoc_cache_tag_lookup
// Self-checking testbench of the set-associative cache tag lookup. A short
// table of directed accesses is followed by random phases, each under its own
// pair of penalty settings. Accesses crowd onto a few sets and tags so that
// hits, fills and dirty evictions are frequent. Every result transfer is
// compared with an expected value: the table's own for its typed rows, else a
// prediction kept by a behavioral copy of the tag, valid, dirty and age state.
// ============================================================================
module tb_set_assoc_cache_tag_lookup;
    import sacl_pkg::*;

    localparam int LINE_BYTES = 16;
    localparam int WAYS       = 4;
    localparam int SETS       = 256;
    localparam int ENTRIES    = WAYS * SETS;
    localparam int OFF_BITS   = $clog2(LINE_BYTES);
    localparam int IDX_BITS   = $clog2(SETS);
    localparam int TAG_W      = ADDR_W - OFF_BITS - IDX_BITS;

    localparam int PHASES          = 6;
    localparam int ITEMS_PER_PHASE = 330;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int SETTLE_CYCLES   = 4;
    localparam int TAIL_CYCLES     = 20;

    localparam logic ACC_READ  = 1'b0;
    localparam logic ACC_WRITE = 1'b1;

    localparam logic [PADDR_W-1:0] ADDR_MISS_PEN = {REG_MISS_PENALTY, 2'b00};
    localparam logic [PADDR_W-1:0] ADDR_WB_PEN   = {REG_WRITEBACK_PENALTY, 2'b00};

    localparam t_result RES_MISS = '{1'b0, 1'b0, CYCLES_W'(MISS_PEN_RESET)};
    localparam t_result RES_HIT  = '{1'b1, 1'b0, '0};
    localparam t_result RES_NONE = '0;

    typedef struct packed {
        t_access acc;
        bit      typed;
        t_result want;
    } t_directed_row;

    localparam int DIRECTED_ROWS = 19;
    localparam t_directed_row DIRECTED [DIRECTED_ROWS] = '{
        '{'{ACC_READ,  64'h0000_0000_0000_0000}, 1'b1, RES_MISS},
        '{'{ACC_READ,  64'h0000_0000_0000_000F}, 1'b1, RES_HIT},
        '{'{ACC_WRITE, 64'h0000_0000_0000_0000}, 1'b1, RES_HIT},
        '{'{ACC_READ,  64'hFFFF_FFFF_FFFF_FFFF}, 1'b1, RES_MISS},
        '{'{ACC_WRITE, 64'hFFFF_FFFF_FFFF_FFF0}, 1'b1, RES_HIT},
        '{'{ACC_READ,  64'h0000_0000_0000_0000}, 1'b1, RES_HIT},
        '{'{ACC_WRITE, 64'h0000_0000_0000_1000}, 1'b1, RES_MISS},
        '{'{ACC_READ,  64'h0000_0000_0000_2000}, 1'b1, RES_MISS},
        '{'{ACC_READ,  64'h0000_0000_0000_3000}, 1'b1, RES_MISS},
        '{'{ACC_READ,  64'h0000_0000_0000_4000}, 1'b0, RES_NONE},
        '{'{ACC_READ,  64'h0000_0000_0000_0000}, 1'b0, RES_NONE},
        '{'{ACC_READ,  64'h0000_0000_0000_0FF0}, 1'b0, RES_NONE},
        '{'{ACC_READ,  64'h8000_0000_0000_0000}, 1'b0, RES_NONE},
        '{'{ACC_WRITE, 64'h5555_5555_5555_5555}, 1'b0, RES_NONE},
        '{'{ACC_READ,  64'hAAAA_AAAA_AAAA_AAAA}, 1'b0, RES_NONE},
        '{'{ACC_WRITE, 64'h0000_0000_0000_4008}, 1'b0, RES_NONE},
        '{'{ACC_READ,  64'h0000_0000_0000_5000}, 1'b0, RES_NONE},
        '{'{ACC_READ,  64'h0000_0000_0000_6000}, 1'b0, RES_NONE},
        '{'{ACC_WRITE, 64'h7FFF_FFFF_FFFF_FFFF}, 1'b0, RES_NONE}
    };

    localparam logic [PEN_W-1:0] MISS_PHASE [PHASES] = '{10'd1023, 10'd0, 10'd0,
                                                          10'd0, 10'd1023, 10'd1};
    localparam logic [PEN_W-1:0] WB_PHASE   [PHASES] = '{10'd1023, 10'd0, 10'd0,
                                                          10'd1023, 10'd0, 10'd512};

    logic                i_clk     = 1'b0;
    logic                i_rst_n   = 1'b0;
    logic                i_in_valid = 1'b0;
    t_access             i_in_data  = '0;
    logic                i_out_ready = 1'b0;
    logic                psel      = 1'b0;
    logic                penable   = 1'b0;
    logic                pwrite    = 1'b0;
    logic [PADDR_W-1:0]  paddr     = '0;
    logic [APB_W-1:0]    pwdata    = '0;
    logic                o_in_ready;
    logic                o_out_valid;
    t_result             o_out_data;
    logic [APB_W-1:0]    prdata;
    logic                pready;

    logic [TAG_W-1:0]    line_tag   [ENTRIES];
    bit                  line_valid [ENTRIES];
    bit                  line_dirty [ENTRIES];
    logic [2:0]          line_age   [ENTRIES];
    logic [PEN_W-1:0]    miss_cycles = MISS_PEN_RESET;
    logic [PEN_W-1:0]    wb_cycles   = WB_PEN_RESET;

    t_result             expected_results [$];
    int                  mismatches  = 0;
    int                  idle_cycles = 0;
    int                  burst_left  = 0;
    logic [15:0]         drain_mask  = 16'hFFFF;
    logic [3:0]          stall_idx   = '0;
    logic [TAG_W-1:0]    tag_pool [6];
    logic [IDX_BITS-1:0] set_pool [3];

    set_assoc_cache_tag_lookup #(
        .LINE_BYTES (LINE_BYTES),
        .WAYS       (WAYS),
        .SETS       (SETS)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        for (int i = 0; i < ENTRIES; i++) begin
            line_tag[i]   = '0;
            line_valid[i] = 1'b0;
            line_dirty[i] = 1'b0;
            line_age[i]   = '0;
        end
    end

    function automatic t_result predict_lookup(input t_access acc);
        logic [TAG_W-1:0] tag;
        int               base;
        int               way;
        int               spare_way;
        bit               found;
        bit               spare;
        logic [2:0]       pivot;
        t_result          res;
        tag       = acc.address[ADDR_W-1 -: TAG_W];
        base      = int'(acc.address[OFF_BITS +: IDX_BITS]) * WAYS;
        found     = 1'b0;
        spare     = 1'b0;
        way       = 0;
        spare_way = 0;
        res       = '0;
        for (int i = 0; i < WAYS; i++) begin
            if (!found) begin
                if (!line_valid[base+i]) begin
                    spare     = 1'b1;
                    spare_way = i;
                end else if (line_tag[base+i] == tag) begin
                    found = 1'b1;
                    way   = i;
                end
            end
        end
        if (!found) begin
            if (spare) begin
                way = spare_way;
            end else begin
                way = 0;
                for (int i = 1; i < WAYS; i++) begin
                    if (line_age[base+i] > line_age[base+way]) begin
                        way = i;
                    end
                end
            end
            res.dirty_writeback = line_valid[base+way] && line_dirty[base+way];
            line_tag[base+way]   = tag;
            line_valid[base+way] = 1'b1;
            line_dirty[base+way] = acc.is_write;
        end else if (acc.is_write) begin
            line_dirty[base+way] = 1'b1;
        end
        pivot = line_age[base+way];
        for (int i = 0; i < WAYS; i++) begin
            if (line_age[base+i] <= pivot && line_age[base+i] < WAYS) begin
                line_age[base+i] = line_age[base+i] + 3'd1;
            end
        end
        line_age[base+way] = '0;
        res.hit            = found;
        res.penalty_cycles = (found ? CYCLES_W'(0) : CYCLES_W'(miss_cycles))
                           + (res.dirty_writeback ? CYCLES_W'(wb_cycles) : CYCLES_W'(0));
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("ERROR %s: got 0x%0h, expected 0x%0h", what, got, want);
        mismatches++;
    endtask

    task automatic send_access(input t_access acc, input bit typed, input t_result want);
        t_result predicted;
        i_in_valid <= 1'b1;
        i_in_data  <= acc;
        do @(posedge i_clk); while (!o_in_ready);
        predicted = predict_lookup(acc);
        expected_results.push_back(typed ? want : predicted);
    endtask

    task automatic pause_sender(input int max_gap);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, max_gap);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end else begin
            burst_left--;
        end
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [PADDR_W-1:0] addr, input logic [PEN_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {(APB_W-PEN_W)'($urandom), value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        if (addr == ADDR_MISS_PEN) begin
            miss_cycles = value;
        end else begin
            wb_cycles = value;
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result", 64'(o_out_data), 64'd0);
            end else begin
                want = expected_results.pop_front();
                if (o_out_data.hit !== want.hit) begin
                    report_mismatch("hit", 64'(o_out_data.hit), 64'(want.hit));
                end
                if (o_out_data.dirty_writeback !== want.dirty_writeback) begin
                    report_mismatch("dirty_writeback", 64'(o_out_data.dirty_writeback),
                                    64'(want.dirty_writeback));
                end
                if (o_out_data.penalty_cycles !== want.penalty_cycles) begin
                    report_mismatch("penalty_cycles", 64'(o_out_data.penalty_cycles),
                                    64'(want.penalty_cycles));
                end
            end
        end
        i_out_ready <= drain_mask[stall_idx];
        stall_idx   <= stall_idx + 4'd1;
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL set_assoc_cache_tag_lookup");
            $finish;
        end
    end

    initial begin : stimulus
        logic [PEN_W-1:0] miss_val;
        logic [PEN_W-1:0] wb_val;
        int               max_gap;
        t_access          acc;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed accesses run under the reset penalties.
        for (int r = 0; r < DIRECTED_ROWS; r++) begin
            if (r > 0) begin
                pause_sender(3);
            end
            send_access(DIRECTED[r].acc, DIRECTED[r].typed, DIRECTED[r].want);
        end
        drain_results();

        for (int p = 0; p < PHASES; p++) begin
            miss_val = (p == 2) ? PEN_W'($urandom) : MISS_PHASE[p];
            wb_val   = (p == 2) ? PEN_W'($urandom) : WB_PHASE[p];
            write_reg(ADDR_MISS_PEN, miss_val);
            write_reg(ADDR_WB_PEN, wb_val);

            for (int t = 0; t < 6; t++) begin
                tag_pool[t] = TAG_W'({$urandom, $urandom});
            end
            tag_pool[0] = (p % 2 == 0) ? '1 : '0;
            for (int s = 0; s < 3; s++) begin
                set_pool[s] = IDX_BITS'($urandom);
            end
            if (p % 2 == 1) begin
                set_pool[0] = '1;
            end

            max_gap = (p % 3 == 0) ? 0 : 5;
            drain_mask <= (p % 3 == 2) ? (16'($urandom) | 16'h0001) : 16'hFFFF;

            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (n > 0) begin
                    pause_sender(max_gap);
                end
                acc.is_write = 1'($urandom);
                if ($urandom_range(0, 9) < 8) begin
                    acc.address = {tag_pool[$urandom_range(0, 5)],
                                   set_pool[$urandom_range(0, 2)],
                                   OFF_BITS'($urandom)};
                end else begin
                    acc.address = {$urandom, $urandom};
                end
                send_access(acc, 1'b0, RES_NONE);
            end
            drain_results();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("PASS set_assoc_cache_tag_lookup");
        end else begin
            $display("FAIL set_assoc_cache_tag_lookup");
        end
        $finish;
    end

endmodule
